>>> rtl/prs_pkg.sv
// shared types, codes and pin-action functions for the power rail sequencer
package prs_pkg;

  // item kinds
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_START   = 2'd1;
  localparam logic [1:0] KIND_DISABLE = 2'd2;

  // configuration register indexes
  localparam logic [0:0] REG_FIRST_DELAY = 1'b0;
  localparam logic [0:0] REG_INTERVAL    = 1'b1;

  // bit positions in the pin level vector
  localparam int PIN_SOFT     = 0;
  localparam int PIN_SAFE_EN  = 1;
  localparam int PIN_CHG_EN   = 2;
  localparam int PIN_SAFE_RST = 3;
  localparam int PIN_CHG_RST  = 4;
  localparam int PIN_STATUS   = 5;
  localparam int PIN_W        = 6;

  localparam int TIMER_W = 16;

  typedef logic [PIN_W-1:0]   pins_t;
  typedef logic [TIMER_W-1:0] timer_t;
  typedef logic [3:0]         step_t;

  // sequence steps
  localparam step_t STEP_SOFT_ON    = 4'd0;
  localparam step_t STEP_STATUS_DIG = 4'd1;
  localparam step_t STEP_EN_ON      = 4'd2;
  localparam step_t STEP_RST_LOW_A  = 4'd3;
  localparam step_t STEP_RST_HIGH   = 4'd4;
  localparam step_t STEP_RST_LOW_B  = 4'd5;
  localparam step_t STEP_STATUS_ANA = 4'd6;
  localparam step_t STEP_EN_OFF     = 4'd7;
  localparam step_t STEP_SOFT_OFF   = 4'd8;
  localparam step_t STEP_DONE       = 4'd9;

  localparam timer_t FIRST_DELAY_RST = 16'd500;
  localparam timer_t INTERVAL_RST    = 16'd250;

  typedef enum logic [2:0] {
    ROLE_STAGE_ON,
    ROLE_STAGE_OFF,
    ROLE_CHG_ON,
    ROLE_CHG_OFF,
    ROLE_NONE
  } role_t;

  function automatic role_t rail_role(input int unsigned idx);
    role_t role;
    case (idx)
      0:       role = ROLE_STAGE_ON;
      1:       role = ROLE_STAGE_OFF;
      2:       role = ROLE_CHG_ON;
      3:       role = ROLE_CHG_OFF;
      default: role = ROLE_NONE;
    endcase
    return role;
  endfunction

  // off rails always pull their enable low
  function automatic pins_t set_enable(input pins_t pins, input role_t role, input logic lvl);
    pins_t p;
    p = pins;
    case (role)
      ROLE_STAGE_ON:  p[PIN_SAFE_EN] = lvl;
      ROLE_STAGE_OFF: p[PIN_SAFE_EN] = 1'b0;
      ROLE_CHG_ON:    p[PIN_CHG_EN]  = lvl;
      ROLE_CHG_OFF:   p[PIN_CHG_EN]  = 1'b0;
      default: ;
    endcase
    return p;
  endfunction

  function automatic pins_t set_reset(input pins_t pins, input role_t role, input logic lvl);
    pins_t p;
    p = pins;
    if (role == ROLE_STAGE_ON || role == ROLE_STAGE_OFF) p[PIN_SAFE_RST] = lvl;
    else if (role == ROLE_CHG_ON || role == ROLE_CHG_OFF) p[PIN_CHG_RST] = lvl;
    return p;
  endfunction

  function automatic pins_t step_pins(input pins_t pins, input role_t role, input step_t step);
    pins_t p;
    logic  stage;
    p = pins;
    stage = (role == ROLE_STAGE_ON) || (role == ROLE_STAGE_OFF);
    case (step)
      STEP_SOFT_ON:    if (role == ROLE_STAGE_ON) p[PIN_SOFT] = 1'b1;
      STEP_STATUS_DIG: if (stage) p[PIN_STATUS] = 1'b1;
      STEP_EN_ON:      p = set_enable(p, role, 1'b1);
      STEP_RST_LOW_A:  p = set_reset(p, role, 1'b0);
      STEP_RST_HIGH:   p = set_reset(p, role, 1'b1);
      STEP_RST_LOW_B:  p = set_reset(p, role, 1'b0);
      STEP_STATUS_ANA: if (stage) p[PIN_STATUS] = 1'b0;
      STEP_EN_OFF:     p = set_enable(p, role, 1'b0);
      STEP_SOFT_OFF:   if (role == ROLE_STAGE_ON) p[PIN_SOFT] = 1'b0;
      default: ;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/power_rail_sequencer.sv
// power rail sequencer top level: rail state, tick scheduling and result register
//
// input channel (in_valid/in_ready) carries one item: a tick, a start request or a
// disable request for one rail; out channel (out_valid/out_ready) returns one
// transfer per item with the pin levels, ready flags and busy flag after the update
// latency: the result is valid the cycle after the input transfer
// throughput: one item per cycle while results are taken; a single pass of a
// priority pick over the rails, one 16-bit timer decrement and compare, and the
// step decode sits between the rail state registers and the result register
// the output register frees in the same cycle it is taken, so in_ready is high
// whenever the result register is empty or being drained
// when the receiver stalls, the held result blocks new input (in_ready low) and
// rail state does not change, so nothing is lost or repeated
// reset (rst_n low, synchronous): all rails finished with no request or done flag,
// timers zero, all pins low, delays back to 500 and 250 ticks, no result pending
// configuration: cfg_we writes register cfg_index (0 first step delay, 1 step
// interval) at once; other indexes are ignored
// a tick only advances the lowest-numbered rail with a pending request
module power_rail_sequencer
  import prs_pkg::*;
#(
  parameter int NUM_RAILS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [1:0]  in_rail,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_soft_start_pin,
  output logic        out_safety_enable_pin,
  output logic        out_charger_enable_pin,
  output logic        out_safety_reset_pin,
  output logic        out_charger_reset_pin,
  output logic        out_status_pins_digital,
  output logic        out_power_stage_ready,
  output logic        out_charger_ready,
  output logic        out_sequence_busy
);

  localparam int RAIL_W = (NUM_RAILS > 1) ? $clog2(NUM_RAILS) : 1;

  // configuration registers
  timer_t first_delay_r;
  timer_t interval_r;

  // per-rail sequencing state
  step_t                step_r    [NUM_RAILS];
  step_t                step_nxt  [NUM_RAILS];
  timer_t               timer_r   [NUM_RAILS];
  timer_t               timer_nxt [NUM_RAILS];
  logic [NUM_RAILS-1:0] req_r, req_nxt;
  logic [NUM_RAILS-1:0] done_r, done_nxt;
  pins_t                pins_r, pins_nxt;

  // result register
  logic  out_valid_r;
  pins_t out_pins_r;
  logic  out_stage_rdy_r, out_chg_rdy_r, out_busy_r;

  logic              accept;
  logic              found;
  logic [RAIL_W-1:0] sel;
  logic [RAIL_W-1:0] rail_idx;
  logic              rail_ok;
  timer_t            tdec;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign rail_idx = RAIL_W'(in_rail);
  assign rail_ok  = (int'(in_rail) < NUM_RAILS);

  // lowest-numbered rail with a pending request
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = NUM_RAILS - 1; i >= 0; i--) begin
      if (req_r[i]) begin
        found = 1'b1;
        sel   = RAIL_W'(i);
      end
    end
  end

  // timer of the picked rail after one tick
  assign tdec = (timer_r[sel] != '0) ? timer_r[sel] - timer_t'(1) : timer_r[sel];

  always_comb begin
    step_nxt  = step_r;
    timer_nxt = timer_r;
    req_nxt   = req_r;
    done_nxt  = done_r;
    pins_nxt  = pins_r;
    if (accept) begin
      case (in_kind)
        KIND_TICK: begin
          if (found) begin
            if (tdec == '0) begin
              // expired: reload and take the current step
              timer_nxt[sel] = interval_r;
              if (step_r[sel] < STEP_DONE) begin
                pins_nxt      = step_pins(pins_r, rail_role(int'(sel)), step_r[sel]);
                step_nxt[sel] = step_r[sel] + step_t'(1);
                if (step_r[sel] == STEP_SOFT_ON) done_nxt[sel] = 1'b0;
                if (step_r[sel] == STEP_SOFT_OFF) begin
                  req_nxt[sel]  = 1'b0;
                  done_nxt[sel] = 1'b1;
                end
              end
            end else begin
              timer_nxt[sel] = tdec;
            end
          end
        end
        KIND_START: begin
          if (rail_ok) begin
            timer_nxt[rail_idx] = first_delay_r;
            step_nxt[rail_idx]  = STEP_SOFT_ON;
            req_nxt[rail_idx]   = 1'b1;
          end
        end
        KIND_DISABLE: begin
          if (rail_ok) begin
            done_nxt[rail_idx] = 1'b0;
            pins_nxt = set_enable(pins_r, rail_role(int'(rail_idx)), 1'b0);
          end
        end
        default: ;
      endcase
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_delay_r <= FIRST_DELAY_RST;
      interval_r    <= INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_DELAY: first_delay_r <= cfg_wdata;
        REG_INTERVAL:    interval_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // rail state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_RAILS; i++) begin
        step_r[i]  <= STEP_DONE;
        timer_r[i] <= '0;
      end
      req_r  <= '0;
      done_r <= '0;
      pins_r <= '0;
    end else begin
      step_r  <= step_nxt;
      timer_r <= timer_nxt;
      req_r   <= req_nxt;
      done_r  <= done_nxt;
      pins_r  <= pins_nxt;
    end
  end

  // result register, loaded with the state after the update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pins_r      <= pins_nxt;
      out_stage_rdy_r <= done_nxt[0];
      out_chg_rdy_r   <= (NUM_RAILS > 2) ? done_nxt[RAIL_W'(2 % NUM_RAILS)] : 1'b0;
      out_busy_r      <= |req_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_soft_start_pin      = out_pins_r[PIN_SOFT];
  assign out_safety_enable_pin   = out_pins_r[PIN_SAFE_EN];
  assign out_charger_enable_pin  = out_pins_r[PIN_CHG_EN];
  assign out_safety_reset_pin    = out_pins_r[PIN_SAFE_RST];
  assign out_charger_reset_pin   = out_pins_r[PIN_CHG_RST];
  assign out_status_pins_digital = out_pins_r[PIN_STATUS];
  assign out_power_stage_ready   = out_stage_rdy_r;
  assign out_charger_ready       = out_chg_rdy_r;
  assign out_sequence_busy       = out_busy_r;

endmodule
